// ===== design/tbvl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbvl_pkg: shared definitions for the threshold best-value lookup
// Table sizing, command codes and the structs exchanged between the
// sequencer and the entry store.
// ----------------------------------------------------------------------------
package tbvl_pkg;

  // Table sizing.
  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths.
  localparam int CMD_W = 2;
  localparam int KEY_W = 16;
  localparam int VAL_W = 16;
  localparam int TOT_W = 32;
  localparam int ENT_W = KEY_W + VAL_W;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Status codes.
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  // Access request from the sequencer to the entry store.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // One finished result.
  typedef struct packed {
    logic             status;
    logic [VAL_W-1:0] best_value;
    logic [TOT_W-1:0] running_total;
  } rslt_t;

endpackage

// ===== design/tbvl_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbvl_store: entry memory
// One write port and one read port; each word packs a threshold over a
// value. Read data is registered.
// ----------------------------------------------------------------------------
module tbvl_store (
  input  logic                      clk,
  input  tbvl_pkg::mem_req_t        req,
  output logic [tbvl_pkg::ENT_W-1:0] rd_data
);

  logic [tbvl_pkg::ENT_W-1:0] mem [tbvl_pkg::TABLE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== design/tbvl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbvl_ctrl: command sequencer and shared compare unit
// Appends entries, clears the table, and for a query walks the stored
// entries one per cycle through a single compare unit, then adds the best
// value into the saturating total.
// ----------------------------------------------------------------------------
module tbvl_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [tbvl_pkg::CMD_W-1:0]     cmd,
  input  logic [tbvl_pkg::KEY_W-1:0]     entry_threshold,
  input  logic [tbvl_pkg::VAL_W-1:0]     entry_value,
  input  logic [tbvl_pkg::KEY_W-1:0]     ability,
  output tbvl_pkg::mem_req_t             mem_req,
  input  logic [tbvl_pkg::ENT_W-1:0]     rd_data,
  output logic                           res_valid,
  input  logic                           res_ready,
  output tbvl_pkg::rslt_t                res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]                    state;
  logic [1:0]                    state_next;
  logic [tbvl_pkg::CNT_W-1:0]    entry_count;
  logic [tbvl_pkg::TOT_W-1:0]    total_acc;
  logic [tbvl_pkg::ADDR_W-1:0]   idx;
  logic                          cmp_valid;
  logic [tbvl_pkg::KEY_W-1:0]    key;
  logic [tbvl_pkg::VAL_W-1:0]    best;
  logic [tbvl_pkg::CMD_W-1:0]    cmd_q;
  logic                          status_q;

  logic                          accept;
  logic                          table_full;
  logic                          last_issue;
  logic [tbvl_pkg::KEY_W-1:0]    rd_thr;
  logic [tbvl_pkg::VAL_W-1:0]    rd_val;
  logic [tbvl_pkg::TOT_W:0]      sum_wide;
  logic [tbvl_pkg::TOT_W-1:0]    sum_sat;
  logic                          emit_done;

  assign accept     = req_valid && !req_stall;
  assign req_stall  = (state != S_IDLE);
  assign table_full = (entry_count == tbvl_pkg::CNT_W'(tbvl_pkg::TABLE_DEPTH));
  assign last_issue = ({1'b0, idx} == (entry_count - tbvl_pkg::CNT_W'(1)));
  assign rd_thr     = rd_data[tbvl_pkg::ENT_W-1:tbvl_pkg::VAL_W];
  assign rd_val     = rd_data[tbvl_pkg::VAL_W-1:0];
  assign emit_done  = (state == S_EMIT) && res_ready;

  // Memory requests: append on a load beat while the table has room, one read per scan cycle.
  always_comb begin
    mem_req.wr_en   = accept && (cmd == tbvl_pkg::CMD_LOAD) && !table_full;
    mem_req.wr_addr = entry_count[tbvl_pkg::ADDR_W-1:0];
    mem_req.wr_data = {entry_threshold, entry_value};
    mem_req.rd_en   = (state == S_SCAN);
    mem_req.rd_addr = idx;
  end

  // Saturating accumulate of the query result.
  assign sum_wide = {1'b0, total_acc} + {{(tbvl_pkg::TOT_W + 1 - tbvl_pkg::VAL_W){1'b0}}, best};
  assign sum_sat  = sum_wide[tbvl_pkg::TOT_W] ? {tbvl_pkg::TOT_W{1'b1}}
                                              : sum_wide[tbvl_pkg::TOT_W-1:0];

  // Result presented in the emit state.
  always_comb begin
    res_valid         = (state == S_EMIT);
    res.status        = status_q;
    res.best_value    = best;
    res.running_total = (cmd_q == tbvl_pkg::CMD_QUERY) ? sum_sat : total_acc;
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((cmd == tbvl_pkg::CMD_QUERY) && (entry_count != '0)) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_SCAN: begin
        if (last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      total_acc   <= '0;
      cmp_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= (state == S_SCAN);
      if (accept && (cmd == tbvl_pkg::CMD_LOAD) && !table_full) begin
        entry_count <= entry_count + tbvl_pkg::CNT_W'(1);
      end else if (accept && (cmd == tbvl_pkg::CMD_CLEAR)) begin
        entry_count <= '0;
      end
      if (accept && (cmd == tbvl_pkg::CMD_CLEAR)) begin
        total_acc <= '0;
      end else if (emit_done && (cmd_q == tbvl_pkg::CMD_QUERY)) begin
        total_acc <= sum_sat;
      end
    end
  end

  // Scan datapath: address counter and the shared compare unit.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= cmd;
      key      <= ability;
      best     <= '0;
      idx      <= '0;
      status_q <= ((cmd == tbvl_pkg::CMD_LOAD) && table_full) ? tbvl_pkg::STAT_FULL
                                                              : tbvl_pkg::STAT_OK;
    end else begin
      if (state == S_SCAN) begin
        idx <= idx + tbvl_pkg::ADDR_W'(1);
      end
      if (cmp_valid && (rd_thr <= key) && (rd_val > best)) begin
        best <= rd_val;
      end
    end
  end

endmodule

// ===== design/threshold_best_value_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_best_value_lookup: best value under a threshold
// Stores threshold/value entries and answers queries with the largest value
// whose threshold does not exceed the given ability.
// ----------------------------------------------------------------------------
// A load beat appends one entry (status reports a dropped entry when the
// table is full), a clear beat empties the table and zeroes the total, and a
// query beat returns the best qualifying value plus the saturating running
// total. Load, clear and spare-code beats go straight to the emit state. A
// query reads the stored entries one word per scan cycle through the single
// compare unit, drains the last registered read, then emits; a query of an
// empty table behaves like a load. The block holds req_stall high from the
// cycle after acceptance until its result enters the output register, which
// can hold a finished beat while the next one is accepted. A stalled result
// channel holds the block in its emit state.
module threshold_best_value_lookup (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [tbvl_pkg::CMD_W-1:0] cmd,
  input  logic [tbvl_pkg::KEY_W-1:0] entry_threshold,
  input  logic [tbvl_pkg::VAL_W-1:0] entry_value,
  input  logic [tbvl_pkg::KEY_W-1:0] ability,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic                       status,
  output logic [tbvl_pkg::VAL_W-1:0] best_value,
  output logic [tbvl_pkg::TOT_W-1:0] running_total
);

  tbvl_pkg::mem_req_t         mem_req;
  logic [tbvl_pkg::ENT_W-1:0] rd_data;
  logic                       res_valid;
  logic                       res_ready;
  tbvl_pkg::rslt_t            res;

  tbvl_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  tbvl_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .cmd             (cmd),
    .entry_threshold (entry_threshold),
    .entry_value     (entry_value),
    .ability         (ability),
    .mem_req         (mem_req),
    .rd_data         (rd_data),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  // Output register: free when empty or when its beat leaves this cycle.
  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      status        <= res.status;
      best_value    <= res.best_value;
      running_total <= res.running_total;
    end
  end

endmodule

// ===== design/tbvl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbvl_port_checks: port-level checks for the lookup block
// Watches the top-level ports and flags result or handshake slips.
// ----------------------------------------------------------------------------
module tbvl_port_checks (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_stall,
  input logic                       rsp_valid,
  input logic                       rsp_stall,
  input logic                       status,
  input logic [tbvl_pkg::VAL_W-1:0] best_value,
  input logic [tbvl_pkg::TOT_W-1:0] running_total
);

  // A stalled result beat holds its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(best_value) && $stable(running_total))
    else $error("stalled result beat changed");

  // The block is busy in the cycle after it takes a beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("block free right after accepting a beat");

  // A dropped load never carries a value.
  a_full_no_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == tbvl_pkg::STAT_FULL) |-> best_value == '0)
    else $error("dropped load reported a best value");

  // The total already includes the best value it reports.
  a_total_covers_best: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> running_total >= {{(tbvl_pkg::TOT_W - tbvl_pkg::VAL_W){1'b0}}, best_value})
    else $error("running total below reported best value");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result pending after reset");

endmodule

bind threshold_best_value_lookup tbvl_port_checks u_tbvl_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req_valid),
  .req_stall     (req_stall),
  .rsp_valid     (rsp_valid),
  .rsp_stall     (rsp_stall),
  .status        (status),
  .best_value    (best_value),
  .running_total (running_total)
);
